// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files; the controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/nb2sd_pkg.sv -----
// Shared types, constants and helper functions for the base-10000 decimal converter.
package nb2sd_pkg;

  localparam int WORD_W           = 16;
  localparam int VALUE_W          = 64;
  localparam int MAX_DIGIT_GROUPS = 64;
  localparam int SEEN_W           = $clog2(MAX_DIGIT_GROUPS + 1);
  localparam int SCALE_W          = 5;
  localparam int SWIDTH_W         = 2;
  localparam int EXP_W            = 3;
  localparam int K_W              = 14;
  localparam int IPOW_W           = 7;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 5;

  localparam logic [SCALE_W-1:0] MAX_SCALE = 5'd18;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_WIDTH = 1'd1;

  localparam logic [SWIDTH_W-1:0] SW_16 = 2'd0;
  localparam logic [SWIDTH_W-1:0] SW_32 = 2'd1;

  localparam logic [WORD_W-1:0] SIGN_POS  = 16'h0000;
  localparam logic [WORD_W-1:0] SIGN_NEG  = 16'h4000;
  localparam logic [WORD_W-1:0] SIGN_NAN  = 16'hC000;
  localparam logic [WORD_W-1:0] SIGN_PINF = 16'hD000;
  localparam logic [WORD_W-1:0] SIGN_NINF = 16'hF000;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NAN      = 3'd1,
    STAT_PINF     = 3'd2,
    STAT_NINF     = 3'd3,
    STAT_BAD_SIGN = 3'd4,
    STAT_TOO_MANY = 3'd5
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_WEIGHT   = 10'b0000000010,
    S_SIGN     = 10'b0000000100,
    S_DSCALE   = 10'b0000001000,
    S_DIGIT    = 10'b0000010000,
    S_MAC      = 10'b0000100000,
    S_INT_POW  = 10'b0001000000,
    S_FRAC_POW = 10'b0010000000,
    S_SUM      = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic start;
    logic ld_weight;
    logic ld_sign;
    logic ld_digit;
    logic mac_digit;
    logic seed;
    logic int_step;
    logic frac_step;
    logic sum;
    logic emit_hdr;
    logic emit_val;
  } cmd_t;

  typedef struct packed {
    logic hdr_bad;
    logic empty;
    logic last_digit;
    logic int_pow_zero;
    logic frac_pow_zero;
  } sts_t;

  // 10^e for e = 0..4
  function automatic logic [K_W-1:0] pow10_small(input logic [EXP_W-1:0] e);
    logic [K_W-1:0] k;
    begin
      case (e)
        3'd0:    k = 14'd1;
        3'd1:    k = 14'd10;
        3'd2:    k = 14'd100;
        3'd3:    k = 14'd1000;
        default: k = 14'd10000;
      endcase
      return k;
    end
  endfunction

  // w / 10^e for e = 1..3, by reciprocal multiply (exact over 16 bits)
  function automatic logic [WORD_W-1:0] div_pow10(input logic [WORD_W-1:0] w,
                                                  input logic [EXP_W-1:0] e);
    logic [31:0] p;
    logic [WORD_W-1:0] q;
    begin
      p = '0;
      case (e)
        3'd1: begin
          p = 32'(w) * 32'd52429;
          q = 16'(p >> 19);
        end
        3'd2: begin
          p = 32'(w >> 2) * 32'd5243;
          q = 16'(p >> 17);
        end
        3'd3: begin
          p = 32'(w >> 3) * 32'd8389;
          q = 16'(p >> 20);
        end
        default: q = w;
      endcase
      return q;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] fit_width(input logic [VALUE_W-1:0] v,
                                                   input logic [SWIDTH_W-1:0] sw);
    logic [VALUE_W-1:0] r;
    begin
      case (sw)
        SW_16:   r = {{48{v[15]}}, v[15:0]};
        SW_32:   r = {{32{v[31]}}, v[31:0]};
        default: r = v;
      endcase
      return r;
    end
  endfunction

  function automatic status_t hdr_status(input logic [WORD_W-1:0] sign,
                                         input logic [WORD_W-1:0] nd);
    status_t s;
    begin
      if (sign == SIGN_NAN)                          s = STAT_NAN;
      else if (sign == SIGN_PINF)                    s = STAT_PINF;
      else if (sign == SIGN_NINF)                    s = STAT_NINF;
      else if (sign != SIGN_POS && sign != SIGN_NEG) s = STAT_BAD_SIGN;
      else if (nd > 16'(MAX_DIGIT_GROUPS))           s = STAT_TOO_MANY;
      else                                           s = STAT_OK;
      return s;
    end
  endfunction

endpackage

// ----- hdl/nb2sd_datapath.sv -----
// Datapath: header registers, accumulators, shared multiply-add and output register.
module nb2sd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nb2sd_pkg::WORD_W-1:0]        word,
  input  logic                                cfg_we,
  input  logic [nb2sd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nb2sd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  nb2sd_pkg::cmd_t                     cmd,
  output nb2sd_pkg::sts_t                     sts,
  output logic [nb2sd_pkg::VALUE_W-1:0]       out_value,
  output nb2sd_pkg::status_t                  out_status
);
  import nb2sd_pkg::*;

  logic [SCALE_W-1:0]  ts_r;
  logic [SWIDTH_W-1:0] sw_r;
  logic [WORD_W-1:0]   nd_r;
  logic [WORD_W-1:0]   weight_r;
  logic [WORD_W-1:0]   sign_r;
  logic [VALUE_W-1:0]  int_r;
  logic [VALUE_W-1:0]  frac_r;
  logic [SEEN_W-1:0]   seen_r;
  logic [EXP_W-1:0]    mac_exp_r;
  logic [WORD_W-1:0]   mac_add_r;
  logic                mac_frac_r;
  logic                mac_en_r;
  logic [IPOW_W-1:0]   int_pow_r;
  logic [SCALE_W-1:0]  frac_pow_r;
  logic [VALUE_W-1:0]  out_value_r;
  status_t             out_status_r;

  logic [SCALE_W-1:0]  sc;
  logic signed [17:0]  seen_x, weight_x, nd_x, p_x, diff, fg;
  logic                is_int, frac_use;
  logic [SCALE_W-1:0]  p4, rem;
  logic [EXP_W-1:0]    dig_exp;
  logic [WORD_W-1:0]   dig_add;
  logic [4:0]          extra;
  logic [SCALE_W-1:0]  filled_raw, filled;
  logic [EXP_W-1:0]    int_exp, frac_exp, mac_e;
  logic [VALUE_W-1:0]  mac_src, mac_res, signed_val;
  logic [WORD_W-1:0]   mac_a;
  status_t             hdr_stat;

  assign sc = (ts_r > MAX_SCALE) ? MAX_SCALE : ts_r;

  // classify the incoming digit group
  always_comb begin
    seen_x   = $signed({{(18-SEEN_W){1'b0}}, seen_r});
    weight_x = $signed({{2{weight_r[15]}}, weight_r});
    p_x      = seen_x - weight_x - 18'sd1;
    is_int   = (p_x < 18'sd0);
    p4       = {p_x[2:0], 2'b00};
    frac_use = !is_int && (p_x < 18'sd5) && (p4 < sc);
    rem      = sc - p4;
    if (is_int || rem >= 5'd4) begin
      dig_exp = 3'd4;
      dig_add = word;
    end else begin
      dig_exp = rem[EXP_W-1:0];
      dig_add = div_pow10(word, 3'(5'd4 - rem));
    end
  end

  // end-of-value alignment counts
  always_comb begin
    nd_x = $signed({{(18-SEEN_W){1'b0}}, nd_r[SEEN_W-1:0]});
    diff = weight_x - nd_x + 18'sd1;
    fg   = -diff;
    if (diff > 18'sd16)     extra = 5'd16;
    else if (diff > 18'sd0) extra = diff[4:0];
    else                    extra = 5'd0;
    if (fg > 18'sd0) filled_raw = (fg >= 18'sd5) ? sc : {fg[2:0], 2'b00};
    else             filled_raw = '0;
    filled = (filled_raw > sc) ? sc : filled_raw;
  end

  assign int_exp  = (int_pow_r >= 7'd4) ? 3'd4 : int_pow_r[EXP_W-1:0];
  assign frac_exp = (frac_pow_r >= 5'd4) ? 3'd4 : frac_pow_r[EXP_W-1:0];

  // shared multiply-add: acc * 10^e + addend, wrapping at 64 bits
  always_comb begin
    if (cmd.mac_digit) begin
      mac_src = mac_frac_r ? frac_r : int_r;
      mac_e   = mac_exp_r;
      mac_a   = mac_add_r;
    end else if (cmd.frac_step) begin
      mac_src = frac_r;
      mac_e   = frac_exp;
      mac_a   = '0;
    end else begin
      mac_src = int_r;
      mac_e   = int_exp;
      mac_a   = '0;
    end
    mac_res = mac_src * 64'(pow10_small(mac_e)) + 64'(mac_a);
  end

  assign signed_val = (sign_r == SIGN_NEG) ? (64'd0 - int_r) : int_r;
  assign hdr_stat   = hdr_status(sign_r, nd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= '0;
      sw_r <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_SCALE:  ts_r <= cfg_data[SCALE_W-1:0];
        CFG_STORAGE_WIDTH: sw_r <= cfg_data[SWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nd_r     <= word;
      weight_r <= '0;
      sign_r   <= '0;
      int_r    <= '0;
      frac_r   <= '0;
      seen_r   <= '0;
    end
    if (cmd.ld_weight) weight_r <= word;
    if (cmd.ld_sign)   sign_r   <= word;
    if (cmd.ld_digit) begin
      mac_exp_r  <= dig_exp;
      mac_add_r  <= dig_add;
      mac_frac_r <= !is_int;
      mac_en_r   <= is_int || frac_use;
    end
    if (cmd.mac_digit) begin
      seen_r <= seen_r + 1'b1;
      if (mac_en_r && !mac_frac_r) int_r  <= mac_res;
      if (mac_en_r && mac_frac_r)  frac_r <= mac_res;
    end
    if (cmd.seed) begin
      int_pow_r  <= 7'({extra, 2'b00}) + {2'b00, sc};
      frac_pow_r <= sc - filled;
    end
    if (cmd.int_step) begin
      int_r     <= mac_res;
      int_pow_r <= int_pow_r - 7'(int_exp);
    end
    if (cmd.frac_step) begin
      frac_r     <= mac_res;
      frac_pow_r <= frac_pow_r - 5'(frac_exp);
    end
    if (cmd.sum) int_r <= int_r + frac_r;
    if (cmd.emit_hdr) begin
      out_value_r  <= '0;
      out_status_r <= hdr_stat;
    end
    if (cmd.emit_val) begin
      out_value_r  <= fit_width(signed_val, sw_r);
      out_status_r <= STAT_OK;
    end
  end

  always_comb begin
    sts.hdr_bad       = (hdr_stat != STAT_OK);
    sts.empty         = (nd_r == '0);
    sts.last_digit    = ({1'b0, 16'(seen_r)} + 17'd1) >= {1'b0, nd_r};
    sts.int_pow_zero  = (int_pow_r == '0);
    sts.frac_pow_zero = (frac_pow_r == '0);
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- hdl/nb2sd_ctrl.sv -----
// Controller: word sequencing, finish sequencing and output valid.
`include "assert_macros.svh"
module nb2sd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tuser,
  output logic            in_tready,
  input  logic            out_tready,
  output logic            out_tvalid,
  input  nb2sd_pkg::sts_t sts,
  output nb2sd_pkg::cmd_t cmd
);
  import nb2sd_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r inside {S_IDLE, S_WEIGHT, S_SIGN, S_DIGIT})
                     || (state_r == S_DSCALE && out_free);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    if (in_fire && in_tuser) begin
      cmd.start = 1'b1;
      state_nxt = S_WEIGHT;
    end else begin
      case (state_r)
        S_IDLE: ;
        S_WEIGHT: if (in_fire) begin
          cmd.ld_weight = 1'b1;
          state_nxt     = S_SIGN;
        end
        S_SIGN: if (in_fire) begin
          cmd.ld_sign = 1'b1;
          state_nxt   = S_DSCALE;
        end
        S_DSCALE: if (in_fire) begin
          if (sts.hdr_bad || sts.empty) begin
            cmd.emit_hdr = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
        S_DIGIT: if (in_fire) begin
          cmd.ld_digit = 1'b1;
          state_nxt    = S_MAC;
        end
        S_MAC: begin
          cmd.mac_digit = 1'b1;
          if (sts.last_digit) begin
            cmd.seed  = 1'b1;
            state_nxt = S_INT_POW;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
        S_INT_POW: begin
          if (sts.int_pow_zero) state_nxt = S_FRAC_POW;
          else                  cmd.int_step = 1'b1;
        end
        S_FRAC_POW: begin
          if (sts.frac_pow_zero) state_nxt = S_SUM;
          else                   cmd.frac_step = 1'b1;
        end
        S_SUM: begin
          cmd.sum   = 1'b1;
          state_nxt = S_DONE;
        end
        S_DONE: if (out_free) begin
          cmd.emit_val = 1'b1;
          state_nxt    = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_comb begin
    if (cmd.emit_hdr || cmd.emit_val) out_valid_nxt = 1'b1;
    else if (out_tready)              out_valid_nxt = 1'b0;
    else                              out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `AST_IMPL(a_emit_into_free, cmd.emit_hdr || cmd.emit_val, !out_valid_r || out_tready)
  `AST_IMPL(a_busy_no_ready, state_r == S_MAC || state_r == S_SUM || state_r == S_DONE, !in_tready)
  `AST_NEXT(a_mac_returns, state_r == S_MAC && !sts.last_digit, state_r == S_DIGIT)

endmodule

// ----- hdl/numeric_base10000_to_scaled_decimal.sv -----
// Top level: base-10000 decimal word stream to scaled fixed-point integer.
//
// A value enters as 16-bit words on the in_ stream: digit count (marked by
// in_tuser = 1), signed weight, sign word, display scale, then the base-10000
// digit groups, most significant first. One result per value leaves on the
// out_ stream: the number scaled by 10^target_scale (fraction digits past the
// scale truncated, a short fraction padded), negated for sign word 0x4000 and
// wrapped and sign-extended from a 16, 32 or 64 bit width (storage_width 0,
// 1, 2; 3 acts as 64). target_scale above 18 acts as 18. NaN, +inf, -inf, a
// bad sign word or more than 64 digit groups give value 0 with a non-zero
// status, right after the display-scale word; a digit count of 0 gives 0 with
// status ok there too. A new digit-count word drops an open value unfinished;
// words with in_tuser = 0 and no value open are taken and ignored.
// Sequence: each header word is taken in turn. Each digit group is taken
// and pre-scaled, then passed through the shared 64 x 14 bit multiply-add
// unit. After the last group that same unit aligns the integral part by
// up to four decimal places a cycle (4*e + s places in all, e = extra
// zero groups up to the weight, at most 16, s = scale), then the fraction
// (s - f places, f = fraction digits already in place), then adds, negates
// and wraps. The input is held off during that work and while a result
// waits on an output that the next value's display-scale word would load.
// Configuration: cfg_index 0 is target_scale, 1 is storage_width; write
// only while no value is open or in flight.
module numeric_base10000_to_scaled_decimal (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [15:0]                         in_tdata,   // [15:0] word
  input  logic                                in_tuser,   // [0] start_req
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [63:0]                         out_tdata,  // [63:0] value
  output logic [2:0]                          out_tuser,  // [2:0] status
  input  logic                                cfg_we,
  input  logic [nb2sd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nb2sd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nb2sd_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  status_t out_status;

  // sequencing of header words, digit transfers and the finish steps
  nb2sd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // accumulators, alignment counters, multiply-add and result register
  nb2sd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .word       (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_value  (out_tdata),
    .out_status (out_status)
  );

  assign out_tuser = 3'(out_status);

endmodule
